/* rtl/core/bsm_pkg.sv */
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the bank switching mapper: item kinds,
// lookup targets, register indexes, and the bank state and status bundles.
// ----------------------------------------------------------------------------
package bsm_pkg;

    typedef enum logic [2:0] {
        KIND_INDEX = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_TICK  = 3'd2,
        KIND_CPU   = 3'd3,
        KIND_PPU   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        TGT_PRG_ROM  = 3'd0,
        TGT_PRG_RAM  = 3'd1,
        TGT_OPEN_BUS = 3'd2,
        TGT_CHR_ROM  = 3'd3,
        TGT_CHR_RAM  = 3'd4,
        TGT_NONE     = 3'd5
    } tgt_t;

    // configuration port indexes
    localparam logic [2:0] CFG_PRG_AND = 3'd0;
    localparam logic [2:0] CFG_PRG_OR  = 3'd1;
    localparam logic [2:0] CFG_CHR_AND = 3'd2;
    localparam logic [2:0] CFG_CHR_OR  = 3'd3;
    localparam logic [2:0] CFG_RAM_ON  = 3'd4;
    localparam logic [2:0] CFG_CHR_ROM = 3'd5;

    // internal register file indexes
    localparam logic [3:0] REG_CHR_FIRST = 4'h0;
    localparam logic [3:0] REG_CHR_LAST  = 4'h7;
    localparam logic [3:0] REG_PRG_FIRST = 4'h8;
    localparam logic [3:0] REG_PRG_LAST  = 4'hB;
    localparam logic [3:0] REG_MIRROR    = 4'hC;
    localparam logic [3:0] REG_IRQ_CTRL  = 4'hD;
    localparam logic [3:0] REG_CNT_LO    = 4'hE;
    localparam logic [3:0] REG_CNT_HI    = 4'hF;

    localparam logic [7:0] PRG_BANK_LAST = 8'hFF;
    localparam logic [7:0] PRG_BANK3_RST = 8'hFE;

    typedef struct packed {
        logic [7:0][7:0] chr;
        logic [3:0][7:0] prg;
        logic [7:0]      prg_and;
        logic [7:0]      prg_or;
        logic [7:0]      chr_and;
        logic [7:0]      chr_or;
        logic            ram_on;
        logic            chr_rom;
    } bsm_banks_t;

    typedef struct packed {
        logic       irq;
        logic [1:0] mirror;
    } bsm_status_t;

endpackage

/* rtl/core/bsm_regs.sv */
// ----------------------------------------------------------------------------
// bsm_regs
// Register file of the mapper: configuration, bank registers, mirroring,
// irq control and the 16-bit irq down counter. Updated once per transaction.
// ----------------------------------------------------------------------------
module bsm_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                step,
    input  logic [2:0]          kind,
    input  logic [7:0]          value,
    output bsm_pkg::bsm_banks_t banks,
    output bsm_pkg::bsm_status_t status_next
);
    import bsm_pkg::*;

    bsm_banks_t  banks_reg;
    bsm_banks_t  banks_next;
    logic [3:0]  sel_reg;
    logic [3:0]  sel_next;
    logic [1:0]  mirror_reg;
    logic [1:0]  mirror_next;
    logic [1:0]  ctrl_reg;
    logic [1:0]  ctrl_next;
    logic [15:0] cnt_reg;
    logic [15:0] cnt_next;
    logic        irq_reg;
    logic        irq_next;

    always_comb
    begin
        banks_next  = banks_reg;
        sel_next    = sel_reg;
        mirror_next = mirror_reg;
        ctrl_next   = ctrl_reg;
        cnt_next    = cnt_reg;
        irq_next    = irq_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PRG_AND: banks_next.prg_and = cfg_data;
                CFG_PRG_OR:  banks_next.prg_or  = cfg_data;
                CFG_CHR_AND: banks_next.chr_and = cfg_data;
                CFG_CHR_OR:  banks_next.chr_or  = cfg_data;
                CFG_RAM_ON:  banks_next.ram_on  = cfg_data[0];
                CFG_CHR_ROM: banks_next.chr_rom = cfg_data[0];
                default:     ;
            endcase
        end

        if (step)
        begin
            unique case (kind)
                KIND_INDEX: sel_next = value[3:0];
                KIND_DATA:
                begin
                    unique case (sel_reg) inside
                        [REG_CHR_FIRST:REG_CHR_LAST]: banks_next.chr[sel_reg[2:0]] = value;
                        [REG_PRG_FIRST:REG_PRG_LAST]: banks_next.prg[sel_reg[1:0]] = value;
                        REG_MIRROR:   mirror_next = value[1:0];
                        REG_IRQ_CTRL:
                        begin
                            ctrl_next = {value[7], value[0]};
                            irq_next  = 1'b0;
                        end
                        REG_CNT_LO:   cnt_next = {cnt_reg[15:8], value};
                        REG_CNT_HI:   cnt_next = {value, cnt_reg[7:0]};
                        default:      ;
                    endcase
                end
                KIND_TICK:
                begin
                    if (ctrl_reg[1])
                    begin
                        cnt_next = cnt_reg - 16'd1;
                        if (cnt_next == 16'd0 && ctrl_reg[0])
                        begin
                            irq_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                banks_reg.chr[i] <= 8'(i);
            end
            banks_reg.prg[0]  <= 8'h00;
            banks_reg.prg[1]  <= 8'h00;
            banks_reg.prg[2]  <= 8'h01;
            banks_reg.prg[3]  <= PRG_BANK3_RST;
            banks_reg.prg_and <= 8'hFF;
            banks_reg.prg_or  <= 8'h00;
            banks_reg.chr_and <= 8'hFF;
            banks_reg.chr_or  <= 8'h00;
            banks_reg.ram_on  <= 1'b0;
            banks_reg.chr_rom <= 1'b1;
            sel_reg           <= 4'h0;
            mirror_reg        <= 2'd0;
            ctrl_reg          <= 2'd0;
            cnt_reg           <= 16'h0000;
            irq_reg           <= 1'b0;
        end
        else
        begin
            banks_reg  <= banks_next;
            sel_reg    <= sel_next;
            mirror_reg <= mirror_next;
            ctrl_reg   <= ctrl_next;
            cnt_reg    <= cnt_next;
            irq_reg    <= irq_next;
        end
    end

    assign banks              = banks_reg;
    assign status_next.irq    = irq_next;
    assign status_next.mirror = mirror_next;

endmodule

/* rtl/core/bsm_xlate.sv */
// ----------------------------------------------------------------------------
// bsm_xlate
// Address translation for cpu and ppu lookups: bank selection, AND/OR bank
// masking, work ram and open bus decode in the 0x6000 window.
// ----------------------------------------------------------------------------
module bsm_xlate (
    input  logic                kind_lookup_cpu,
    input  logic                kind_lookup_ppu,
    input  logic [15:0]         address,
    input  bsm_pkg::bsm_banks_t banks,
    output bsm_pkg::tgt_t       target,
    output logic [20:0]         mapped_address
);
    import bsm_pkg::*;

    logic [7:0] prg_raw;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic [1:0] prg_idx;
    logic [7:0] p0;
    logic [5:0] ram_bank;

    assign p0       = banks.prg[0];
    assign prg_idx  = address[14:13] + 2'd1;
    assign ram_bank = banks.ram_on ? p0[5:0] : 6'd0;
    assign chr_bank = (banks.chr[address[12:10]] & banks.chr_and) | banks.chr_or;

    always_comb
    begin
        case (address[15:13])
            3'd3:    prg_raw = {2'b00, p0[5:0]};
            3'd7:    prg_raw = PRG_BANK_LAST;
            default: prg_raw = banks.prg[prg_idx];
        endcase
    end

    assign prg_bank = (prg_raw & banks.prg_and) | banks.prg_or;

    always_comb
    begin
        target         = TGT_NONE;
        mapped_address = 21'd0;
        if (kind_lookup_cpu)
        begin
            if (address[15:13] == 3'd3 && p0[6])
            begin
                if (p0[7])
                begin
                    target         = TGT_PRG_RAM;
                    mapped_address = {2'b00, ram_bank, address[12:0]};
                end
                else
                begin
                    target = TGT_OPEN_BUS;
                end
            end
            else if (address[15] || address[14:13] == 2'd3)
            begin
                target         = TGT_PRG_ROM;
                mapped_address = {prg_bank, address[12:0]};
            end
        end
        else if (kind_lookup_ppu)
        begin
            if (address[15:13] == 3'd0)
            begin
                target         = banks.chr_rom ? TGT_CHR_ROM : TGT_CHR_RAM;
                mapped_address = {3'b000, chr_bank, address[9:0]};
            end
        end
    end

endmodule

/* rtl/core/bank_switching_mapper_with_irq_counter_unit.sv */
// ----------------------------------------------------------------------------
// bank_switching_mapper_with_irq_counter_unit
// Cartridge mapper with index/data register file and irq down counter.
//
// Input channel (in_valid, in_stall, kind, value, address) carries one bus
// event per transaction: index write, data write, cpu tick, cpu lookup or
// ppu lookup. Output channel (out_valid, out_stall, irq_asserted,
// mirror_mode, target, mapped_address) returns exactly one result per input
// transaction, in order, showing irq line and mirroring after the event.
// Each event passes one input register, then the register file update and
// translation logic feed the result register. Throughput is one transaction
// per clock while out_stall is low; the register file updates as an item
// moves into the result register, so the next item sees its effect with no
// bubble. A stalled result holds; the input register still takes one more
// transaction, after which in_stall follows out_stall.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect on the
// clock edge; the user makes them while no transaction is in flight, which
// the block does not enforce. Reset (rst_n low, asynchronous) empties both
// registers and restores the default bank, mask, mirroring and irq state.
// ----------------------------------------------------------------------------
module bank_switching_mapper_with_irq_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  value,
    input  logic [15:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        irq_asserted,
    output logic [1:0]  mirror_mode,
    output logic [2:0]  target,
    output logic [20:0] mapped_address
);
    import bsm_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  value_reg;
    logic [15:0] address_reg;
    logic        out_valid_reg;
    logic        irq_reg;
    logic [1:0]  mirror_reg;
    tgt_t        tgt_reg;
    logic [20:0] maddr_reg;

    logic        out_advance;
    logic        fire;
    logic        in_load;
    bsm_banks_t  banks;
    bsm_status_t status_next;
    tgt_t        tgt_next;
    logic [20:0] maddr_next;

    assign out_advance = !out_valid_reg || !out_stall;
    assign fire        = in_valid_reg && out_advance;
    assign in_load     = !in_valid_reg || out_advance;
    assign in_stall    = !in_load;

    bsm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (fire),
        .kind        (kind_reg),
        .value       (value_reg),
        .banks       (banks),
        .status_next (status_next)
    );

    bsm_xlate u_xlate (
        .kind_lookup_cpu (kind_reg == KIND_CPU),
        .kind_lookup_ppu (kind_reg == KIND_PPU),
        .address         (address_reg),
        .banks           (banks),
        .target          (tgt_next),
        .mapped_address  (maddr_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            kind_reg    <= kind;
            value_reg   <= value;
            address_reg <= address;
        end
        if (fire)
        begin
            irq_reg    <= status_next.irq;
            mirror_reg <= status_next.mirror;
            tgt_reg    <= tgt_next;
            maddr_reg  <= maddr_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign irq_asserted   = irq_reg;
    assign mirror_mode    = mirror_reg;
    assign target         = tgt_reg;
    assign mapped_address = maddr_reg;

endmodule
